[hw/rtl/heavy_hitter_decay_sketch_assert.svh]
// Assertion macros for the heavy-hitter decay sketch.
`ifndef HEAVY_HITTER_DECAY_SKETCH_ASSERT_SVH
`define HEAVY_HITTER_DECAY_SKETCH_ASSERT_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define HHDS_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define HHDS_ASSERT(lbl, prop, msg) \
  `HHDS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/hhds_pkg.sv]
// Types, constants and the decay table of the heavy-hitter decay sketch.
package hhds_pkg;

  localparam int unsigned BUCKETS     = 1024;
  localparam int unsigned HEAVY_CELLS = 8;
  localparam int unsigned LIGHT_CELLS = 64;

  localparam int unsigned BUCKET_W    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CELL_IDX_W  = (HEAVY_CELLS > 1) ? $clog2(HEAVY_CELLS) : 1;
  localparam int unsigned LIGHT_IDX_W = (LIGHT_CELLS > 1) ? $clog2(LIGHT_CELLS) : 1;
  localparam int unsigned STEP_W      = (CELL_IDX_W > 2) ? CELL_IDX_W : 2;

  localparam int unsigned COUNT_W = 20;
  localparam int unsigned FP_W    = 16;
  localparam int unsigned LIGHT_W = 4;
  localparam int unsigned LIMIT_W = 13;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned RAND_W  = 16;
  localparam int unsigned THR_W   = 17;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [LIGHT_W-1:0] LIGHT_MAX = '1;

  localparam logic [31:0] HASH_SEED = 32'd131;
  localparam logic [31:0] HASH_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] MIX_C1    = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2    = 32'hc2b2_ae35;
  localparam logic [63:0] INV_RATE_Q32 = 64'd3976821570;

  localparam logic [COUNT_W-1:0] THRESHOLD_RST = 20'd750;
  localparam logic [LIMIT_W-1:0] LIMIT_RST     = 13'd6000;

  // Register indexes (byte address bit 2)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  // Request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam int unsigned THR_TAB_DEPTH = 256;
  localparam int unsigned THR_IDX_W     = 8;

  typedef struct packed {
    logic              func;
    logic [KEY_W-1:0]  key;
    logic [RAND_W-1:0] rand_value;
  } hhds_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               reported;
    logic [KEY_W-1:0]   reported_key;
  } hhds_out_t;

  typedef struct packed {
    logic [FP_W-1:0]    fp;
    logic [COUNT_W-1:0] cnt;
  } cell_t;

  typedef cell_t [HEAVY_CELLS-1:0] heavy_row_t;
  typedef logic [LIGHT_CELLS-1:0][LIGHT_W-1:0] light_row_t;

  // Shared multiply unit operation: y = (a ^ (xsh ? a >> sh : 0)) * b + c
  typedef struct packed {
    logic        en;
    logic        xsh;
    logic [4:0]  sh;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hhds_mul_op_t;

  typedef struct packed {
    logic                   rd_en;
    logic [BUCKET_W-1:0]    addr;
    logic                   heavy_we;
    logic [CELL_IDX_W-1:0]  cell_idx;
    cell_t                  wr_cell;
    logic                   light_we;
    logic [LIGHT_IDX_W-1:0] light_idx;
    logic [LIGHT_W-1:0]     light_val;
  } hhds_store_req_t;

  typedef struct packed {
    logic                  match_v;
    logic [CELL_IDX_W-1:0] match_idx;
    logic [COUNT_W-1:0]    match_cnt;
    logic                  empty_v;
    logic [CELL_IDX_W-1:0] empty_idx;
    logic [CELL_IDX_W-1:0] weak_idx;
    cell_t                 weak_cell;
  } hhds_scan_t;

  typedef logic [THR_W-1:0] thr_tab_t [THR_TAB_DEPTH];

  // Decay threshold per count: t starts at 2^32 and is scaled by 1/1.08 (Q0.32)
  function automatic thr_tab_t decay_tab_gen();
    thr_tab_t    tab;
    logic [63:0] t;
    t = 64'h1_0000_0000;
    for (int k = 0; k < THR_TAB_DEPTH; k++) begin
      tab[k] = t[32:16];
      t = (t * INV_RATE_Q32) >> 32;
    end
    return tab;
  endfunction

  localparam thr_tab_t DecayThr = decay_tab_gen();

endpackage

[hw/rtl/heavy_hitter_decay_sketch.sv]
// Top level of the heavy-hitter decay sketch: sequencer, update logic, registers.
//
//   channel   direction  handshake            payload
//   in        in         in_valid/in_ready    in_data_i  (hhds_in_t: func, key, rand_value)
//   out       out        out_valid/out_ready  out_data_o (hhds_out_t: count, reported, key)
//   cfg       in         APB psel/penable     paddr, pwdata, prdata (threshold, limit)
//
// A request passes from acceptance to the result register through four hash
// passes and two fingerprint-mix passes through the one shared multiplier, a scan
// of the bucket's heavy cells one per cycle, and an update step. in_ready is high
// only in idle, so a new request is taken only once the last one is done.
// After reset a sweep clears the memories one bucket row per cycle; in_ready
// stays low meanwhile, config writes still work.
// The update cycle waits while an earlier result is still held on the output.
module heavy_hitter_decay_sketch
  import hhds_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hhds_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hhds_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

`include "heavy_hitter_decay_sketch_assert.svh"

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HASH   = 3'd1;
  localparam logic [2:0] ST_MIX1   = 3'd2;
  localparam logic [2:0] ST_MIX2   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;

  logic [2:0]         state_d, state_q;
  logic [STEP_W-1:0]  step_d, step_q;
  hhds_in_t           req_q;
  logic [31:0]        h_q;
  logic [COUNT_W-1:0] thr_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] reports_d, reports_q;
  hhds_out_t          out_d, out_q;
  logic               out_valid_q;

  hhds_mul_op_t       mul_op;
  logic [31:0]        mul_y;
  logic [31:0]        hash_w;
  logic [7:0]         key_byte;
  logic [FP_W-1:0]    fp;

  hhds_store_req_t    st_req;
  heavy_row_t         heavy_row;
  light_row_t         light_row;
  logic               store_busy;

  logic               scan_load;
  logic               scan_step;
  hhds_scan_t         scan;

  logic               in_fire;
  logic               upd_fire;
  logic               cfg_wr;
  logic [LIGHT_IDX_W-1:0] lidx;
  logic [LIGHT_W-1:0]     light_val;
  logic [THR_W-1:0]       decay_thr;
  logic                   decay;
  logic [COUNT_W-1:0]     new_cnt;

  // ---------------- shared multiplier ----------------
  hhds_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mul_op),
    .y_o    (mul_y)
  );

  hhds_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (st_req),
    .heavy_row_o (heavy_row),
    .light_row_o (light_row),
    .busy_o      (store_busy)
  );

  hhds_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (scan_load),
    .row_i  (heavy_row),
    .step_i (scan_step),
    .fp_i   (fp),
    .st_o   (scan)
  );

  assign in_ready_o = (state_q == ST_IDLE) && !store_busy;
  assign in_fire    = in_valid_i && in_ready_o;
  assign upd_fire   = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);

  // key bytes MSB first: step 0 takes bits 31..24
  assign key_byte = req_q.key[{~step_q[1:0], 3'b000} +: 8];
  assign hash_w   = mul_y & HASH_MASK;
  // low 16 bits of the final fmix32 xor-shift
  assign fp       = mul_y[FP_W-1:0] ^ mul_y[31:16];
  assign lidx     = LIGHT_IDX_W'(h_q % LIGHT_CELLS);
  assign light_val = light_row[lidx];

  // ---------------- multiplier operand select ----------------
  always_comb begin
    mul_op     = '0;
    mul_op.b   = HASH_SEED;
    case (state_q)
      ST_HASH: begin
        mul_op.en = 1'b1;
        mul_op.a  = (step_q == '0) ? '0 : mul_y;
        mul_op.c  = {24'd0, key_byte};
      end
      ST_MIX1: begin
        mul_op.en  = 1'b1;
        mul_op.xsh = 1'b1;
        mul_op.sh  = 5'd16;
        mul_op.a   = hash_w;
        mul_op.b   = MIX_C1;
      end
      ST_MIX2: begin
        mul_op.en  = 1'b1;
        mul_op.xsh = 1'b1;
        mul_op.sh  = 5'd13;
        mul_op.a   = mul_y;
        mul_op.b   = MIX_C2;
      end
      default: mul_op.en = 1'b0;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    scan_load = 1'b0;
    scan_step = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_HASH;
          step_d  = '0;
        end
      end
      ST_HASH: begin
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(3)) begin
          state_d = ST_MIX1;
        end
      end
      ST_MIX1: state_d = ST_MIX2;
      ST_MIX2: begin
        // bucket row is in the read register now
        scan_load = 1'b1;
        step_d    = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        step_d    = step_q + 1'b1;
        if (step_q == STEP_W'(HEAVY_CELLS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- update decision ----------------
  always_comb begin
    st_req       = '0;
    st_req.addr  = BUCKET_W'(h_q % BUCKETS);
    out_d        = '0;
    reports_d    = reports_q;
    decay_thr    = '0;
    decay        = 1'b0;
    new_cnt      = '0;

    if (state_q == ST_MIX1) begin
      st_req.rd_en = 1'b1;
      st_req.addr  = BUCKET_W'(hash_w % BUCKETS);
    end

    if (scan.weak_cell.cnt < COUNT_W'(THR_TAB_DEPTH)) begin
      decay_thr = DecayThr[scan.weak_cell.cnt[THR_IDX_W-1:0]];
    end
    st_req.light_idx = lidx;

    if (req_q.func == FUNC_QUERY) begin
      out_d.count = scan.match_v ? scan.match_cnt : COUNT_W'(light_val);
    end else if (scan.match_v) begin
      // hit: saturating increment, report exactly at the threshold while under the limit
      if (scan.match_cnt != COUNT_MAX) begin
        new_cnt             = scan.match_cnt + 1'b1;
        st_req.heavy_we     = upd_fire;
        st_req.cell_idx     = scan.match_idx;
        st_req.wr_cell.fp   = fp;
        st_req.wr_cell.cnt  = new_cnt;
        if (reports_q < limit_q && new_cnt == thr_q) begin
          out_d.reported     = 1'b1;
          out_d.reported_key = req_q.key;
          reports_d          = reports_q + 1'b1;
        end
      end
    end else if (scan.empty_v) begin
      st_req.heavy_we    = upd_fire;
      st_req.cell_idx    = scan.empty_idx;
      st_req.wr_cell.fp  = fp;
      st_req.wr_cell.cnt = COUNT_W'(1);
    end else begin
      // all cells taken: weakest may decay, replaced when it hits zero
      decay           = {1'b0, req_q.rand_value} < decay_thr;
      new_cnt         = scan.weak_cell.cnt - 1'b1;
      st_req.cell_idx = scan.weak_idx;
      if (decay) begin
        st_req.heavy_we = upd_fire;
        if (new_cnt == '0) begin
          st_req.wr_cell.fp  = fp;
          st_req.wr_cell.cnt = COUNT_W'(1);
        end else begin
          st_req.wr_cell.fp  = scan.weak_cell.fp;
          st_req.wr_cell.cnt = new_cnt;
        end
      end
      if (!(decay && new_cnt == '0) && light_val != LIGHT_MAX) begin
        st_req.light_we  = upd_fire;
        st_req.light_val = light_val + 1'b1;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      reports_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (upd_fire) begin
        reports_q   <= reports_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
    if (state_q == ST_MIX1) begin
      h_q <= hash_w;
    end
    if (upd_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_THRESHOLD: thr_q   <= pwdata[COUNT_W-1:0];
        REG_LIMIT:     limit_q <= pwdata[LIMIT_W-1:0];
        default:       thr_q   <= thr_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = PDATA_W'(thr_q);
      REG_LIMIT:     prdata = PDATA_W'(limit_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- assertions ----------------
  `HHDS_ASSERT(a_no_accept_while_clearing, store_busy |-> !in_ready_o, "accept during clear")
  `HHDS_ASSERT(a_accept_starts_hash, in_fire |=> (state_q == ST_HASH), "accept without hash")
  `HHDS_ASSERT(a_reports_step, (reports_q - $past(reports_q)) <= LIMIT_W'(1), "report jump")
  `HHDS_ASSERT(a_rep_cnt, out_valid_o && out_data_o.reported |-> out_data_o.count == '0, "rep")

endmodule

[hw/rtl/hhds_mul.sv]
// Shared xor-shift / multiply / add unit used for hashing and fingerprint mixing.
module hhds_mul import hhds_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  hhds_mul_op_t op_i,
  output logic [31:0]  y_o
);

  logic [31:0] a_x;
  logic [31:0] y_d, y_q;

  always_comb begin
    a_x = op_i.xsh ? (op_i.a ^ (op_i.a >> op_i.sh)) : op_i.a;
    y_d = 32'(a_x * op_i.b + op_i.c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q <= '0;
    end else if (op_i.en) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[hw/rtl/hhds_store.sv]
// Heavy-cell and light-counter memories with the clearing sweep after reset.
module hhds_store import hhds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hhds_store_req_t req_i,
  output heavy_row_t      heavy_row_o,
  output light_row_t      light_row_o,
  output logic            busy_o
);

  heavy_row_t heavy_mem [BUCKETS];
  light_row_t light_mem [BUCKETS];

  heavy_row_t          heavy_rd_q;
  light_row_t          light_rd_q;
  logic                clr_q;
  logic [BUCKET_W-1:0] clr_addr_q;

  // one row per cycle until every bucket is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == BUCKET_W'(BUCKETS - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      heavy_mem[clr_addr_q] <= '0;
      light_mem[clr_addr_q] <= '0;
    end else begin
      if (req_i.heavy_we) begin
        heavy_mem[req_i.addr][req_i.cell_idx] <= req_i.wr_cell;
      end
      if (req_i.light_we) begin
        light_mem[req_i.addr][req_i.light_idx] <= req_i.light_val;
      end
    end
    if (req_i.rd_en) begin
      heavy_rd_q <= heavy_mem[req_i.addr];
      light_rd_q <= light_mem[req_i.addr];
    end
  end

  assign heavy_row_o = heavy_rd_q;
  assign light_row_o = light_rd_q;
  assign busy_o      = clr_q;

endmodule

[hw/rtl/hhds_scan.sv]
// Cell scanner: rotates a bucket row one cell per cycle while stepped and tracks match, empty and weakest.
module hhds_scan import hhds_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  heavy_row_t      row_i,
  input  logic            step_i,
  input  logic [FP_W-1:0] fp_i,
  output hhds_scan_t      st_o
);

  heavy_row_t            row_d, row_q;
  hhds_scan_t            st_d, st_q;
  logic                  weak_v_d, weak_v_q;
  logic [CELL_IDX_W-1:0] idx_d, idx_q;
  cell_t                 head;

  always_comb begin
    row_d    = row_q;
    st_d     = st_q;
    weak_v_d = weak_v_q;
    idx_d    = idx_q;
    head     = row_q[0];
    if (load_i) begin
      row_d    = row_i;
      st_d     = '0;
      weak_v_d = 1'b0;
      idx_d    = '0;
    end else if (step_i) begin
      for (int j = 0; j < HEAVY_CELLS; j++) begin
        row_d[j] = row_q[(j + 1) % HEAVY_CELLS];
      end
      idx_d = idx_q + 1'b1;
      if (head.cnt != '0) begin
        if (!st_q.match_v && head.fp == fp_i) begin
          st_d.match_v   = 1'b1;
          st_d.match_idx = idx_q;
          st_d.match_cnt = head.cnt;
        end
        // strict less-than keeps the lowest index on a tie
        if (!weak_v_q || head.cnt < st_q.weak_cell.cnt) begin
          weak_v_d       = 1'b1;
          st_d.weak_idx  = idx_q;
          st_d.weak_cell = head;
        end
      end else if (!st_q.empty_v) begin
        st_d.empty_v   = 1'b1;
        st_d.empty_idx = idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      weak_v_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      st_q     <= st_d;
      weak_v_q <= weak_v_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign st_o = st_q;

endmodule

[tb/heavy_hitter_decay_sketch_tb.sv]
// Self-checking testbench for the heavy-hitter decay sketch.
`timescale 1ns / 100ps

module heavy_hitter_decay_sketch_tb;
  import hhds_pkg::*;

  localparam int unsigned HEAVY_TOTAL = BUCKETS * HEAVY_CELLS;
  localparam int unsigned LIGHT_TOTAL = BUCKETS * LIGHT_CELLS;
  localparam int unsigned LIMIT_MAX   = 8191;

  // Receiver stall patterns
  typedef enum int unsigned {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PERIODIC
  } ready_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  hhds_in_t           in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  hhds_out_t          out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  heavy_hitter_decay_sketch dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sketch mirror: heavy cells, light counters, report bookkeeping, registers.
  // Updated in request order at the edge where each request is accepted.
  // ---------------------------------------------------------------------------
  logic [FP_W-1:0]    cell_fp_m  [HEAVY_TOTAL];
  logic [COUNT_W-1:0] cell_cnt_m [HEAVY_TOTAL];
  logic [LIGHT_W-1:0] light_m    [LIGHT_TOTAL];
  logic [LIMIT_W-1:0] reports_m;
  logic [COUNT_W-1:0] threshold_m;
  logic [LIMIT_W-1:0] limit_m;

  hhds_out_t   pending_results[$];  // results owed by the block, oldest first
  logic [31:0] hot_keys[$];         // keys crowded into a few buckets
  int unsigned fail_count    = 0;
  int unsigned burst_left    = 0;
  bit          idle_enable   = 1'b1;
  int unsigned holdoff_cycles = 0;  // set by a test, served by the ready driver

  // Byte-wise multiplicative hash, seed 131, top bit dropped
  function automatic logic [31:0] flow_hash(input logic [31:0] key);
    logic [31:0] h;
    h = '0;
    for (int b = 3; b >= 0; b--) h = h * 32'd131 + key[8*b +: 8];
    return h & 32'h7FFF_FFFF;
  endfunction

  // 32-bit finalizer mix, low half kept
  function automatic logic [FP_W-1:0] flow_fingerprint(input logic [31:0] h);
    logic [31:0] x;
    x = h;
    x = x ^ (x >> 16);
    x = x * 32'h85eb_ca6b;
    x = x ^ (x >> 13);
    x = x * 32'hc2b2_ae35;
    x = x ^ (x >> 16);
    return x[FP_W-1:0];
  endfunction

  // Decay cutoff for count n: 2^32 scaled n times by 1/1.08 in Q0.32, top 16 of 32
  function automatic logic [31:0] decay_cutoff(input logic [COUNT_W-1:0] n);
    logic [63:0] t;
    int unsigned k;
    t = 64'h1_0000_0000;
    k = 0;
    while (k < n && t != 0) begin
      t = (t * 64'd3976821570) >> 32;
      k++;
    end
    return t[47:16];
  endfunction

  function automatic void clear_sketch_model();
    for (int i = 0; i < HEAVY_TOTAL; i++) begin
      cell_fp_m[i]  = '0;
      cell_cnt_m[i] = '0;
    end
    for (int i = 0; i < LIGHT_TOTAL; i++) light_m[i] = '0;
    reports_m   = '0;
    threshold_m = 20'd750;
    limit_m     = 13'd6000;
  endfunction

  // Applies one request to the mirror and returns the result it owes
  function automatic hhds_out_t sketch_update(input hhds_in_t req);
    logic [31:0]     h;
    logic [FP_W-1:0] fp;
    int unsigned     base, lidx, p;
    int              hit, vacant, weakest;
    bit              taken;
    hhds_out_t       res;
    h       = flow_hash(req.key);
    fp      = flow_fingerprint(h);
    base    = (h % BUCKETS) * HEAVY_CELLS;
    lidx    = (h % BUCKETS) * LIGHT_CELLS + h % LIGHT_CELLS;
    hit     = -1;
    vacant  = -1;
    weakest = -1;
    taken   = 1'b0;
    res     = '0;
    // only live cells match; weakest is the lowest count, lowest index on a tie
    for (int i = 0; i < HEAVY_CELLS; i++) begin
      if (cell_cnt_m[base + i] != 0) begin
        if (hit < 0 && cell_fp_m[base + i] == fp) hit = i;
        if (weakest < 0 || cell_cnt_m[base + i] < cell_cnt_m[base + weakest]) weakest = i;
      end else if (vacant < 0) begin
        vacant = i;
      end
    end

    if (req.func == FUNC_QUERY) begin
      if (hit >= 0) res.count = cell_cnt_m[base + hit];
      else res.count = COUNT_W'(light_m[lidx]);
      return res;
    end

    if (hit >= 0) begin
      p = base + hit;
      // a saturated count is frozen and cannot hit the threshold again
      if (cell_cnt_m[p] != COUNT_MAX) begin
        cell_cnt_m[p] = cell_cnt_m[p] + 1'b1;
        if (reports_m < limit_m && cell_cnt_m[p] == threshold_m) begin
          reports_m        = reports_m + 1'b1;
          res.reported     = 1'b1;
          res.reported_key = req.key;
        end
      end
    end else if (vacant >= 0) begin
      // claiming a cell starts at one and never reports
      cell_fp_m[base + vacant]  = fp;
      cell_cnt_m[base + vacant] = COUNT_W'(1);
    end else begin
      p = base + weakest;
      if (req.rand_value < decay_cutoff(cell_cnt_m[p])) begin
        cell_cnt_m[p] = cell_cnt_m[p] - 1'b1;
        if (cell_cnt_m[p] == 0) begin
          cell_fp_m[p]  = fp;
          cell_cnt_m[p] = COUNT_W'(1);
          taken         = 1'b1;
        end
      end
      if (!taken && light_m[lidx] != LIGHT_MAX) light_m[lidx] = light_m[lidx] + 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic hhds_in_t make_req(input logic func, input logic [31:0] key,
                                        input logic [RAND_W-1:0] rv);
    hhds_in_t req;
    req.func       = func;
    req.key        = key;
    req.rand_value = rv;
    return req;
  endfunction

  // Decay draws lean on the extremes so both decay outcomes show up often
  function automatic logic [RAND_W-1:0] decay_draw();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3:       return RAND_W'($urandom_range(0, 255));
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // A bucket whose first heavy cell was never claimed is untouched
  function automatic int unsigned fresh_bucket();
    int unsigned b;
    do b = $urandom_range(0, BUCKETS - 1);
    while (cell_cnt_m[b * HEAVY_CELLS] != 0);
    return b;
  endfunction

  function automatic void add_bucket_keys(input int unsigned bucket, input int unsigned n);
    logic [31:0] k;
    repeat (n) begin
      do k = $urandom;
      while (flow_hash(k) % BUCKETS != bucket);
      hot_keys.push_back(k);
    end
  endfunction

  // Mostly crowded keys with a skew toward the head of the list, some stray keys
  function automatic hhds_in_t random_request();
    hhds_in_t req;
    req.func = ($urandom_range(0, 3) == 0) ? FUNC_QUERY : FUNC_INSERT;
    if (hot_keys.size() == 0 || $urandom_range(0, 6) == 0) req.key = $urandom;
    else req.key = hot_keys[$urandom_range(0, $urandom_range(0, hot_keys.size() - 1))];
    req.rand_value = decay_draw();
    return req;
  endfunction

  // Sends one request in bursts with random gaps; valid stays up between
  // back-to-back requests and is only dropped when a gap is taken.
  task automatic issue_request(input hhds_in_t req);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = 0;
      if (idle_enable && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i);
    while (!in_ready_o);
    pending_results.push_back(sketch_update(req));
  endtask

  // Drops valid and waits until every owed result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i);
    while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  // Setup phase, then access phase until pready, then idle
  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_THRESHOLD) threshold_m = value[COUNT_W-1:0];
    else limit_m = value[LIMIT_W-1:0];
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    hhds_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with none owed: count %0d reported %0b key %h",
                 $time, out_data_o.count, out_data_o.reported, out_data_o.reported_key);
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.count !== want.count) begin
          fail_count++;
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, out_data_o.count);
        end
        if (out_data_o.reported !== want.reported) begin
          fail_count++;
          $display("%0t: reported mismatch: expected %0b, actual %0b",
                   $time, want.reported, out_data_o.reported);
        end
        if (out_data_o.reported_key !== want.reported_key) begin
          fail_count++;
          $display("%0t: reported_key mismatch: expected %h, actual %h",
                   $time, want.reported_key, out_data_o.reported_key);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: cycles through stall patterns; serves a long hold-off on demand,
  // counting the cycles here so the sender keeps pushing meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : out_ready_drive
    ready_mode_e mode;
    int unsigned mode_left, tick;
    mode      = READY_ALWAYS;
    mode_left = 0;
    tick      = 0;
    forever begin
      if (holdoff_cycles != 0) begin
        out_ready_i <= 1'b0;
        repeat (holdoff_cycles) @(posedge clk_i);
        holdoff_cycles = 0;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 160);
        end
        mode_left--;
        tick++;
        case (mode)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
          READY_MOSTLY: out_ready_i <= ($urandom_range(0, 7) != 0);
          default:      out_ready_i <= ((tick % 5) >= 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Both functions, key and decay-draw extremes, reset register values
  task automatic test_basic_requests();
    issue_request(make_req(FUNC_QUERY,  32'h0000_0000, '0));  // empty: light count 0
    issue_request(make_req(FUNC_INSERT, 32'h0000_0000, '0));  // claim
    issue_request(make_req(FUNC_INSERT, 32'h0000_0000, '1));  // match, count 2
    issue_request(make_req(FUNC_QUERY,  32'h0000_0000, '1));
    issue_request(make_req(FUNC_INSERT, 32'hFFFF_FFFF, '1));
    issue_request(make_req(FUNC_QUERY,  32'hFFFF_FFFF, '0));
  endtask

  // One bucket overfilled: claims with threshold one never report, a tie of
  // weakest cells decays the lowest index and gets taken over, a failed decay
  // bumps the shared light counter which a miss query then returns.
  task automatic test_bucket_contention();
    wait_drained();
    write_register(REG_THRESHOLD, 32'd1);
    hot_keys.delete();
    add_bucket_keys(fresh_bucket(), HEAVY_CELLS + 2);
    for (int i = 0; i < HEAVY_CELLS; i++)
      issue_request(make_req(FUNC_INSERT, hot_keys[i], decay_draw()));
    issue_request(make_req(FUNC_INSERT, hot_keys[HEAVY_CELLS], '0));
    issue_request(make_req(FUNC_INSERT, hot_keys[HEAVY_CELLS + 1], '1));
    issue_request(make_req(FUNC_QUERY,  hot_keys[HEAVY_CELLS + 1], '0));
    issue_request(make_req(FUNC_QUERY,  hot_keys[1], '0));
  endtask

  // First key reaches the threshold and reports; the second reaches it after
  // the report budget is spent and stays silent.
  task automatic test_report_limit();
    wait_drained();
    write_register(REG_THRESHOLD, 32'd3);
    write_register(REG_LIMIT, 32'd1);
    hot_keys.delete();
    add_bucket_keys(fresh_bucket(), 2);
    repeat (3) issue_request(make_req(FUNC_INSERT, hot_keys[0], decay_draw()));
    repeat (3) issue_request(make_req(FUNC_INSERT, hot_keys[1], decay_draw()));
  endtask

  // Phases of crowded traffic, each under its own register setting
  task automatic test_random_traffic();
    logic [31:0] thr;
    int unsigned lim;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      if (ph == 0) begin
        thr = 0;                 // threshold zero: nothing may report
        lim = LIMIT_MAX;
      end else if (ph == 1) begin
        thr = COUNT_MAX;
        lim = 0;
      end else begin
        thr = ($urandom_range(0, 4) == 0) ? $urandom_range(11, COUNT_MAX)
                                          : $urandom_range(2, 10);
        if ($urandom_range(0, 2) == 0) lim = reports_m + $urandom_range(0, 3);
        else lim = $urandom_range(0, LIMIT_MAX);
        if (lim > LIMIT_MAX) lim = LIMIT_MAX;
      end
      write_register(REG_THRESHOLD, thr);
      write_register(REG_LIMIT, lim);
      hot_keys.delete();
      repeat ($urandom_range(1, 2))
        add_bucket_keys($urandom_range(0, BUCKETS - 1), HEAVY_CELLS + $urandom_range(1, 6));
      repeat (90) issue_request(random_request());
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and holds in_ready low.
  task automatic test_output_holdoff();
    wait_drained();
    write_register(REG_THRESHOLD, $urandom_range(2, 8));
    hot_keys.delete();
    add_bucket_keys($urandom_range(0, BUCKETS - 1), HEAVY_CELLS + 3);
    idle_enable    = 1'b0;
    holdoff_cycles = 1500;
    repeat (40) issue_request(random_request());
    idle_enable = 1'b1;
  endtask

  initial begin : test_sequence
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    clear_sketch_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the block clears its memories first; in_ready holds requests off meanwhile
    test_basic_requests();
    test_bucket_contention();
    test_report_limit();
    test_random_traffic();
    test_output_holdoff();

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #1_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[heavy_hitter_decay_sketch.f]
+incdir+hw/rtl
hw/rtl/hhds_pkg.sv
hw/rtl/hhds_mul.sv
hw/rtl/hhds_store.sv
hw/rtl/hhds_scan.sv
hw/rtl/heavy_hitter_decay_sketch.sv
tb/heavy_hitter_decay_sketch_tb.sv
